### sv/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 7;
   localparam int ROW_MAX_W   = 6;

   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [7:0] NEWLINE_CODE       = 8'd10;
   localparam logic [7:0] SPACE_CODE         = 8'd32;
   localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;

   typedef struct packed {
      logic [1:0]             command;
      logic                   at_position;
      logic [ROW_FIELD_W-1:0] row;
      logic [COL_FIELD_W-1:0] col;
      logic [7:0]             char_code;
      logic [7:0]             attr;
   } req_type;

   typedef struct packed {
      logic [ROW_FIELD_W-1:0] cursor_row;
      logic [COL_FIELD_W-1:0] cursor_col;
      logic [7:0]             cell_char;
      logic [7:0]             cell_attr;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_CLEAR,
      OP_READ,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic                   use_cursor;
      logic [ROW_MAX_W-1:0]   row;
      logic [COL_FIELD_W-1:0] col;
      logic [7:0]             char_code;
      logic [7:0]             attr;
   } entry_type;

endpackage

### sv/tcw_front.sv
// Front end: holds the default attribute and decodes each request into a queue entry.
module tcw_front #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [7:0]         csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  tcw_pkg::req_type   req_data,
   output logic               push_valid,
   input  logic               push_ready,
   output tcw_pkg::entry_type push_entry
);
   import tcw_pkg::*;

   localparam int ROW_LAST = ROWS - 1;
   localparam int COL_LAST = COLS - 1;

   logic [7:0] default_attr_ff;
   logic [7:0] default_attr_in;

   always_comb begin
      default_attr_in = csr_write_en ? csr_write_data : default_attr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_attr_ff <= DEFAULT_ATTR_RESET;
      end else begin
         default_attr_ff <= default_attr_in;
      end
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

   always_comb begin
      push_entry.use_cursor = !req_data.at_position;
      push_entry.char_code  = req_data.char_code;
      if (int'(req_data.row) > ROW_LAST) begin
         push_entry.row = ROW_MAX_W'(ROW_LAST);
      end else begin
         push_entry.row = ROW_MAX_W'(req_data.row);
      end
      if (int'(req_data.col) > COL_LAST) begin
         push_entry.col = COL_FIELD_W'(COL_LAST);
      end else begin
         push_entry.col = req_data.col;
      end
      push_entry.attr = (req_data.attr == 8'd0) ? default_attr_ff : req_data.attr;
      unique case (req_data.command)
         CMD_PUT: begin
            push_entry.op = (req_data.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
         end
         CMD_CLEAR: begin
            push_entry.op   = OP_CLEAR;
            push_entry.attr = default_attr_ff;
         end
         CMD_READ: begin
            push_entry.op = OP_READ;
         end
         CMD_NONE: begin
            push_entry.op = OP_NOP;
         end
      endcase
   end

endmodule

### sv/tcw_queue.sv
// Two-entry queue of decoded commands between the front end and the back end.
module tcw_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  tcw_pkg::entry_type push_entry,
   output logic               pop_valid,
   input  logic               pop_ready,
   output tcw_pkg::entry_type pop_entry
);
   import tcw_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
   a_ptr_balance: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");
   a_ptr_equal: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

### sv/tcw_back.sv
// Back end: cell memory, cursor, scroll and clear sweeps, and the response register.
module tcw_back #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  tcw_pkg::entry_type pop_entry,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tcw_pkg::rsp_type   rsp_data
);
   import tcw_pkg::*;

   localparam int CELLS  = ROWS * COLS;
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLS);
   localparam int CELL_W = $clog2(CELLS);
   localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLS - 1);
   localparam logic [CELL_W-1:0] COLS_CELL  = CELL_W'(COLS);
   localparam logic [CELL_W-1:0] CELL_LAST  = CELL_W'(CELLS - 1);
   localparam logic [CELL_W-1:0] LAST_ROW_0 = CELL_W'(CELLS - COLS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_SCROLL_END,
      ST_ZERO,
      ST_CLEAR
   } state_type;

   logic [15:0] cell_mem_ff [CELLS];

   state_type         state_ff,      state_in;
   logic [ROW_W-1:0]  cur_row_ff,    cur_row_in;
   logic [COL_W-1:0]  cur_col_ff,    cur_col_in;
   logic [CELL_W-1:0] sweep_ff,      sweep_in;
   logic [7:0]        clear_attr_ff, clear_attr_in;
   logic              copy_valid_ff, copy_valid_in;
   logic [CELL_W-1:0] copy_dst_ff,   copy_dst_in;
   logic              rsp_valid_ff,  rsp_valid_in;
   rsp_type           rsp_data_ff,   rsp_data_in;
   logic [15:0]       rd_data_ff;

   logic              out_free;
   logic              done;
   logic [7:0]        rd_char;
   logic [7:0]        rd_attr;
   logic [ROW_W-1:0]  sel_row;
   logic [COL_W-1:0]  sel_col;
   logic [CELL_W-1:0] tgt_addr;
   logic              mem_we;
   logic [CELL_W-1:0] mem_waddr;
   logic [15:0]       mem_wdata;
   logic [CELL_W-1:0] mem_raddr;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == ST_IDLE) && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign sel_row  = pop_entry.use_cursor ? cur_row_ff : ROW_W'(pop_entry.row);
   assign sel_col  = pop_entry.use_cursor ? cur_col_ff : COL_W'(pop_entry.col);
   assign tgt_addr = CELL_W'(sel_row) * COLS_CELL + CELL_W'(sel_col);

   always_comb begin
      state_in      = state_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      sweep_in      = sweep_ff;
      clear_attr_in = clear_attr_ff;
      copy_valid_in = 1'b0;
      copy_dst_in   = copy_dst_ff;
      mem_we        = copy_valid_ff;
      mem_waddr     = copy_dst_ff;
      mem_wdata     = rd_data_ff;
      mem_raddr     = sweep_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      done          = 1'b0;
      rd_char       = 8'd0;
      rd_attr       = 8'd0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid && out_free) begin
               unique case (pop_entry.op)
                  OP_PUT, OP_NEWLINE: begin
                     if (pop_entry.op == OP_PUT) begin
                        mem_we    = 1'b1;
                        mem_waddr = tgt_addr;
                        mem_wdata = {pop_entry.attr, pop_entry.char_code};
                     end
                     if (pop_entry.op == OP_PUT && sel_col != COL_LAST) begin
                        cur_row_in = sel_row;
                        cur_col_in = COL_W'(sel_col + 1'b1);
                        done       = 1'b1;
                     end else begin
                        cur_col_in = '0;
                        if (sel_row == ROW_LAST) begin
                           cur_row_in = sel_row;
                           sweep_in   = COLS_CELL;
                           state_in   = ST_SCROLL;
                        end else begin
                           cur_row_in = ROW_W'(sel_row + 1'b1);
                           done       = 1'b1;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     cur_row_in    = '0;
                     cur_col_in    = '0;
                     sweep_in      = '0;
                     clear_attr_in = pop_entry.attr;
                     state_in      = ST_CLEAR;
                  end
                  OP_READ: begin
                     mem_raddr = tgt_addr;
                     state_in  = ST_READ;
                  end
                  OP_NOP: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rd_char  = rd_data_ff[7:0];
            rd_attr  = rd_data_ff[15:8];
            done     = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SCROLL: begin
            mem_raddr     = sweep_ff;
            copy_valid_in = 1'b1;
            copy_dst_in   = sweep_ff - COLS_CELL;
            if (sweep_ff == CELL_LAST) begin
               state_in = ST_SCROLL_END;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_SCROLL_END: begin
            sweep_in = LAST_ROW_0;
            state_in = ST_ZERO;
         end
         ST_ZERO: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = 16'd0;
            if (sweep_ff == CELL_LAST) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = {clear_attr_ff, SPACE_CODE};
            if (sweep_ff == CELL_LAST) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (done) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.cursor_row = ROW_FIELD_W'(cur_row_in);
         rsp_data_in.cursor_col = COL_FIELD_W'(cur_col_in);
         rsp_data_in.cell_char  = rd_char;
         rsp_data_in.cell_attr  = rd_attr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_row_ff    <= '0;
         cur_col_ff    <= '0;
         copy_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         copy_valid_ff <= copy_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sweep_ff      <= sweep_in;
      clear_attr_ff <= clear_attr_in;
      copy_dst_ff   <= copy_dst_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= cell_mem_ff[mem_raddr];
   end

`ifndef NO_ASSERTIONS
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (cur_row_ff <= ROW_LAST) && (cur_col_ff <= COL_LAST))
      else $error("cursor outside the screen");
   a_copy_in_scroll: assert property (@(posedge clock) disable iff (reset)
      copy_valid_ff |-> (state_ff == ST_SCROLL || state_ff == ST_SCROLL_END))
      else $error("row copy write outside a scroll");
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL || state_ff == ST_ZERO)
         |-> (cur_row_ff == ROW_LAST && cur_col_ff == '0))
      else $error("scroll with cursor not at start of last row");
   a_read_follows_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> ($past(state_ff) == ST_IDLE))
      else $error("read cycle not started from idle");
   a_busy_no_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !pop_ready)
      else $error("queue popped while a sweep runs");
`endif

endmodule

### sv/text_console_writer.sv
// Text console writer: top level joining front end, command queue and back end.
//
// A request on req_valid/req_ready carries one command: put a character at the
// cursor or at a given cell, clear the screen, read one cell, or do nothing.
// Each request gives one response on rsp_valid/rsp_ready: the cursor position
// after the command and, for a read, the cell's character and attribute.
// The default attribute is written through csr_write_en/csr_write_data; the
// user must write it only while the block is idle, as the block does not
// enforce this. It resets to 15. A request passes the decoder straight into
// a two-entry queue. A put is written to a queue slot, popped by the idle
// back end and registered as the response; a read also passes the memory
// read register and the read state. The cell memory has one write and one
// read port; the back end takes one put per cycle while the response register
// is free. A put past the last cell, or a newline in the last row, scrolls;
// a clear sweeps all cells; memory is busy until the sweep ends and responds.
// A stalled receiver holds the response register; up to two further requests
// are still taken into the queue. Reset empties the queue, homes the cursor
// and drops any pending response; cell contents are undefined until written.
module text_console_writer #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [7:0]       csr_write_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tcw_pkg::rsp_type rsp_data
);
   import tcw_pkg::*;

   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   tcw_front #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_entry     (push_entry)
   );

   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   tcw_back #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### test/tb_text_console_writer.sv
// Self-checking testbench for the text console writer: directed and random requests.
module tb_text_console_writer;
   timeunit 1ns;
   timeprecision 1ps;

   import tcw_pkg::*;

   localparam int ROWS        = 25;
   localparam int COLS        = 80;
   localparam int CELLS       = ROWS * COLS;
   localparam int SETTLE_WAIT = CELLS + 100;
   localparam int CYCLE_LIMIT = 10_000_000;

   logic       clock;
   logic       reset          = 1'b1;
   logic       csr_write_en   = 1'b0;
   logic [7:0] csr_write_data = DEFAULT_ATTR_RESET;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   req_type    req_data       = '0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   rsp_type    rsp_data;

   logic [15:0] screen_cells [CELLS];
   bit          cell_written [CELLS];
   int          cursor_pos         = 0;
   logic [7:0]  default_attr_model = DEFAULT_ATTR_RESET;
   rsp_type     expected_rsp [$];
   rsp_type     oldest_rsp;

   int idle_pct     = 17;
   int hold_target  = 0;
   int held         = 0;
   int mismatches   = 0;
   int cycle_count  = 0;

   text_console_writer #(.ROWS(ROWS), .COLS(COLS)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // The receiver honors a requested hold-off before returning to random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (held < hold_target) begin
         rsp_ready <= 1'b0;
         held <= held + 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: row %0d col %0d char %02h attr %02h",
                        rsp_data.cursor_row, rsp_data.cursor_col,
                        rsp_data.cell_char, rsp_data.cell_attr);
         end else begin
            oldest_rsp = expected_rsp.pop_front();
            if (rsp_data.cursor_row !== oldest_rsp.cursor_row ||
                rsp_data.cursor_col !== oldest_rsp.cursor_col ||
                rsp_data.cell_char  !== oldest_rsp.cell_char  ||
                rsp_data.cell_attr  !== oldest_rsp.cell_attr) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%0d %02h/%02h, got %0d/%0d %02h/%02h",
                           oldest_rsp.cursor_row, oldest_rsp.cursor_col,
                           oldest_rsp.cell_char, oldest_rsp.cell_attr,
                           rsp_data.cursor_row, rsp_data.cursor_col,
                           rsp_data.cell_char, rsp_data.cell_attr);
            end
         end
      end
   end

   function automatic int pick_target(req_type r);
      int rr;
      int cc;
      if (!r.at_position)
         return cursor_pos;
      rr = (int'(r.row) >= ROWS) ? ROWS - 1 : int'(r.row);
      cc = (int'(r.col) >= COLS) ? COLS - 1 : int'(r.col);
      return rr * COLS + cc;
   endfunction

   function automatic rsp_type console_step(req_type r);
      rsp_type    o;
      int         pos;
      logic [7:0] a;
      o = '0;
      case (r.command)
         CMD_PUT: begin
            a = (r.attr == 8'd0) ? default_attr_model : r.attr;
            pos = pick_target(r);
            if (r.char_code == NEWLINE_CODE) begin
               pos = (pos / COLS + 1) * COLS;
            end else begin
               screen_cells[pos] = {a, r.char_code};
               cell_written[pos] = 1'b1;
               pos++;
            end
            if (pos >= CELLS) begin
               for (int i = 0; i < CELLS - COLS; i++) begin
                  screen_cells[i] = screen_cells[i + COLS];
                  cell_written[i] = cell_written[i + COLS];
               end
               for (int i = CELLS - COLS; i < CELLS; i++) begin
                  screen_cells[i] = 16'h0000;
                  cell_written[i] = 1'b1;
               end
               pos -= COLS;
            end
            cursor_pos = pos;
         end
         CMD_CLEAR: begin
            for (int i = 0; i < CELLS; i++) begin
               screen_cells[i] = {default_attr_model, SPACE_CODE};
               cell_written[i] = 1'b1;
            end
            cursor_pos = 0;
         end
         CMD_READ: begin
            pos = pick_target(r);
            o.cell_char = screen_cells[pos][7:0];
            o.cell_attr = screen_cells[pos][15:8];
         end
         default: begin
         end
      endcase
      o.cursor_row = ROW_FIELD_W'((cursor_pos / COLS) & 'h1F);
      o.cursor_col = COL_FIELD_W'(cursor_pos % COLS);
      return o;
   endfunction

   function automatic req_type make_req(logic [1:0] cmd, logic at, logic [4:0] row,
                                        logic [6:0] col, logic [7:0] ch, logic [7:0] attr);
      req_type r;
      r.command     = cmd;
      r.at_position = at;
      r.row         = row;
      r.col         = col;
      r.char_code   = ch;
      r.attr        = attr;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(0, 99);
      r.command = (pick < 62) ? CMD_PUT : (pick < 92) ? CMD_READ :
                  (pick < 95) ? CMD_CLEAR : CMD_NONE;
      r.at_position = ($urandom_range(0, 99) < 35);
      r.row = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, ROWS - 1))
                                         : 5'($urandom_range(0, 31));
      r.col = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, COLS - 1))
                                         : 7'($urandom_range(0, 127));
      r.char_code = ($urandom_range(0, 99) < 12) ? NEWLINE_CODE
                                                 : 8'($urandom_range(0, 255));
      r.attr = ($urandom_range(0, 99) < 25) ? 8'd0 : 8'($urandom_range(0, 255));
      // Cells are undefined until written, so such a read becomes a put.
      if (r.command == CMD_READ && !cell_written[pick_target(r)])
         r.command = CMD_PUT;
      return r;
   endfunction

   task automatic send_request(input req_type r);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      expected_rsp.push_back(console_step(r));
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++)
         send_request(random_request());
   endtask

   task automatic wait_all_responses();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   // The block gets a quiet stretch before the default attribute changes.
   task automatic settle_idle();
      wait_all_responses();
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic set_default_attr(input logic [7:0] value);
      settle_idle();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      default_attr_model = value;
   endtask

   task automatic test_directed();
      send_request(make_req(CMD_PUT,   1'b0, 5'd0,  7'd0,   8'h48, 8'h00));
      send_request(make_req(CMD_PUT,   1'b0, 5'd0,  7'd0,   8'h69, 8'h1E));
      send_request(make_req(CMD_READ,  1'b1, 5'd0,  7'd0,   8'h00, 8'h00));
      send_request(make_req(CMD_NONE,  1'b0, 5'd0,  7'd0,   8'h00, 8'h00));
      send_request(make_req(CMD_PUT,   1'b0, 5'd0,  7'd0,   NEWLINE_CODE, 8'h00));
      send_request(make_req(CMD_CLEAR, 1'b0, 5'd0,  7'd0,   8'h00, 8'h00));
      send_request(make_req(CMD_READ,  1'b0, 5'd0,  7'd0,   8'h00, 8'h00));
      send_request(make_req(CMD_PUT,   1'b1, 5'd31, 7'd127, 8'hFF, 8'hFF));
      send_request(make_req(CMD_READ,  1'b1, 5'd23, 7'd79,  8'h00, 8'h00));
      send_request(make_req(CMD_READ,  1'b1, 5'd24, 7'd79,  8'h00, 8'h00));
      send_request(make_req(CMD_PUT,   1'b0, 5'd0,  7'd0,   8'h00, 8'h01));
      send_request(make_req(CMD_PUT,   1'b1, 5'd24, 7'd40,  NEWLINE_CODE, 8'h00));
      send_request(make_req(CMD_READ,  1'b1, 5'd30, 7'd100, 8'h00, 8'h00));
      send_request(make_req(CMD_PUT,   1'b1, 5'd0,  7'd79,  8'h78, 8'h80));
      send_request(make_req(CMD_PUT,   1'b0, 5'd0,  7'd0,   NEWLINE_CODE, 8'hFF));
      send_request(make_req(CMD_READ,  1'b0, 5'd0,  7'd0,   8'h00, 8'h00));
      send_request(make_req(CMD_READ,  1'b1, 5'd0,  7'd79,  8'h00, 8'h00));
      send_request(make_req(CMD_NONE,  1'b1, 5'd31, 7'd127, 8'hFF, 8'hFF));
      send_request(make_req(CMD_PUT,   1'b1, 5'd12, 7'd0,   NEWLINE_CODE, 8'h00));
      send_request(make_req(CMD_READ,  1'b1, 5'd0,  7'd0,   8'h00, 8'h00));
   endtask

   task automatic test_steady_stream();
      idle_pct <= 0;
      send_random(150);
      idle_pct <= 17;
   endtask

   task automatic test_receiver_hold();
      hold_target <= hold_target + 400;
      send_random(30);
   endtask

   task automatic test_drain_pause();
      for (int i = 0; i < 3; i++) begin
         send_random(20);
         wait_all_responses();
      end
   endtask

   task automatic test_default_attr();
      logic [7:0] settings [5];
      settings = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)),
                   8'($urandom_range(1, 254)), DEFAULT_ATTR_RESET};
      foreach (settings[i]) begin
         set_default_attr(settings[i]);
         send_random(140);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_steady_stream();
      test_receiver_hold();
      test_drain_pause();
      test_default_attr();
      settle_idle();
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
